@@ hw/rtl/acss_pkg.sv @@
// acss_pkg: shared constants, register indexes and byte helpers for the
// caseless substring search block; no dependencies
package acss_pkg;

    // default sizes
    localparam int MAX_NEEDLE_DEF  = 32;
    localparam int OFFSET_BITS_DEF = 32;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int LEN_REG_W  = 6;
    localparam int WORD_W     = 64;
    localparam int NUM_WORDS  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int MATCH_W    = 32;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LENGTH = 3'd0,
        CFG_NEEDLE_WORD_0 = 3'd1,
        CFG_NEEDLE_WORD_1 = 3'd2,
        CFG_NEEDLE_WORD_2 = 3'd3,
        CFG_NEEDLE_WORD_3 = 3'd4
    } t_cfg_idx;

    // ascii letter bounds
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_DIFF  = 8'h20;

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
            r = b + CASE_DIFF;
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= CH_LOWER_A && b <= CH_LOWER_Z) begin
            r = b - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/ascii_caseless_substring_search.sv @@
// ascii_caseless_substring_search: leftmost caseless needle search over a
// byte stream, one haystack byte per clock unless a result stalls; depends on acss_pkg
//
// Takes one haystack byte per cycle on the slave stream (tlast marks the
// last byte of a buffer) and gives at most one result per buffer: found with
// the start offset of the leftmost match as soon as the match completes, or
// not-found on the buffer's last byte. Every byte passes an input register
// and then a parallel window compare into the result register, so a result
// is registered behind the input register, and a new byte is taken in every
// cycle while the result register is free or being drained.
// The needle (pre-lowered, up to MAX_NEEDLE bytes) is to be written through the
// configuration port while the block is idle; the block does not enforce this.
module ascii_caseless_substring_search #(
    parameter int MAX_NEEDLE  = acss_pkg::MAX_NEEDLE_DEF,
    parameter int OFFSET_BITS = acss_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [acss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [acss_pkg::WORD_W-1:0]       i_cfg_data,
    // haystack stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] text_byte
    input  logic                              s_axis_tlast,   // end_of_buffer
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [acss_pkg::MATCH_W-1:0]      m_axis_tdata,   // [31:0] match_offset
    output logic                              m_axis_tuser    // [0] found
);
    import acss_pkg::*;

    localparam int LEN_W  = $clog2(MAX_NEEDLE + 1);
    localparam int HIST_D = MAX_NEEDLE - 1;
    localparam int EXT_W  = (OFFSET_BITS > MATCH_W) ? OFFSET_BITS : MATCH_W;
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

    // configuration registers
    logic [LEN_REG_W-1:0]          r_needle_len;
    logic [WORD_W-1:0]             r_needle_word [NUM_WORDS];

    // input register
    logic                          r_in_valid;
    logic [BYTE_W-1:0]             r_in_byte;
    logic                          r_in_last;

    // buffer state
    logic [BYTE_W-1:0]             r_hist [HIST_D];
    logic [OFFSET_BITS-1:0]        r_seen;
    logic                          r_reported;

    // result register
    logic                          r_out_valid;
    logic                          r_out_found;
    logic [MATCH_W-1:0]            r_out_offset;

    logic                          out_free;
    logic                          s1_fire;
    logic [BYTE_W-1:0]             low_byte;
    logic [LEN_W-1:0]              eff_len;
    logic [LEN_W-1:0]              eff_len_m1;
    logic [NUM_WORDS*WORD_W-1:0]   needle_flat;
    logic [MAX_NEEDLE*BYTE_W-1:0]  needle_rev;
    logic [MAX_NEEDLE*BYTE_W-1:0]  needle_aligned;
    logic [LEN_W+2:0]              align_sh;
    logic [MAX_NEEDLE-1:0]         pos_ok;
    logic                          hit;
    logic [OFFSET_BITS-1:0]        start;
    logic [EXT_W-1:0]              start_ext;
    logic                          res_valid;
    logic                          n_out_valid;

    // handshake: result register parts the two sides
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_fire       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || s1_fire;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_len <= '0;
            for (int w = 0; w < NUM_WORDS; w++) begin
                r_needle_word[w] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NEEDLE_LENGTH: r_needle_len     <= i_cfg_data[LEN_REG_W-1:0];
                CFG_NEEDLE_WORD_0: r_needle_word[0] <= i_cfg_data;
                CFG_NEEDLE_WORD_1: r_needle_word[1] <= i_cfg_data;
                CFG_NEEDLE_WORD_2: r_needle_word[2] <= i_cfg_data;
                CFG_NEEDLE_WORD_3: r_needle_word[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // effective needle length, clamped to the window size
    always_comb begin
        if (r_needle_len > LEN_REG_W'(MAX_NEEDLE)) begin
            eff_len = LEN_W'(MAX_NEEDLE);
        end else begin
            eff_len = LEN_W'(r_needle_len);
        end
        eff_len_m1 = eff_len - LEN_W'(1);
    end

    // needle reversed and shifted so byte j lines up with window byte j
    always_comb begin
        needle_flat = {r_needle_word[3], r_needle_word[2],
                       r_needle_word[1], r_needle_word[0]};
        for (int i = 0; i < MAX_NEEDLE; i++) begin
            needle_rev[i*BYTE_W +: BYTE_W] = needle_flat[(MAX_NEEDLE-1-i)*BYTE_W +: BYTE_W];
        end
        align_sh       = {LEN_W'(MAX_NEEDLE) - eff_len, 3'b000};
        needle_aligned = needle_rev >> align_sh;
    end

    // window compare: newest byte at position 0
    assign low_byte = to_lower(r_in_byte);

    always_comb begin
        pos_ok[0] = (low_byte == needle_aligned[BYTE_W-1:0]);
        for (int j = 1; j < MAX_NEEDLE; j++) begin
            pos_ok[j] = (r_hist[j-1] == needle_aligned[j*BYTE_W +: BYTE_W])
                        || (j >= int'(eff_len));
        end
    end

    // match decision and start offset
    always_comb begin
        hit   = 1'b0;
        start = '0;
        if (eff_len == '0) begin
            hit = 1'b1;
        end else if (eff_len == LEN_W'(1)) begin
            hit   = (r_in_byte == needle_flat[BYTE_W-1:0])
                    || (r_in_byte == to_upper(needle_flat[BYTE_W-1:0]));
            start = r_seen;
        end else if (r_seen >= OFFSET_BITS'(eff_len_m1)) begin
            hit   = &pos_ok;
            start = r_seen - OFFSET_BITS'(eff_len_m1);
        end
        start_ext = EXT_W'(start);
        res_valid = !r_reported && (hit || r_in_last);
    end

    // byte history, count and report flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_D; k++) begin
                r_hist[k] <= '0;
            end
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else if (s1_fire) begin
            if (r_in_last) begin
                for (int k = 0; k < HIST_D; k++) begin
                    r_hist[k] <= '0;
                end
                r_seen     <= '0;
                r_reported <= 1'b0;
            end else begin
                r_hist[0] <= low_byte;
                for (int k = 1; k < HIST_D; k++) begin
                    r_hist[k] <= r_hist[k-1];
                end
                if (r_seen != COUNT_MAX) begin
                    r_seen <= r_seen + OFFSET_BITS'(1);
                end
                if (res_valid && hit) begin
                    r_reported <= 1'b1;
                end
            end
        end
    end

    // result register control
    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_fire && res_valid) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (s1_fire && res_valid) begin
            r_out_found  <= hit;
            r_out_offset <= hit ? start_ext[MATCH_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_offset;
    assign m_axis_tuser  = r_out_found;

`ifndef SYNTHESIS
    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !s1_fire)
        else $error("result register overwritten while stalled");

    // last byte of a buffer clears the buffer state
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_in_last) |=> (r_seen == '0 && !r_reported))
        else $error("buffer state not cleared after last byte");

    // a found result marks the buffer as reported
    a_report_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && res_valid && hit && !r_in_last) |=> r_reported)
        else $error("report flag not set after match");

    // no second result within one buffer
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_reported) |-> !res_valid)
        else $error("second result in one buffer");

    // a not-found result carries a zero offset
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_offset == '0))
        else $error("not-found result with nonzero offset");
`endif

endmodule
